@@ rtl/order_reservation_amount_calc_defines.svh @@
// ---------------------------------------------------------------------------
// Order reservation amount calculator: assertion macros
// Shared concurrent assertion helpers clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ORDER_RESERVATION_AMOUNT_CALC_DEFINES_SVH
`define ORDER_RESERVATION_AMOUNT_CALC_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ORAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never true
`define ORAC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/orac_pkg.sv @@
// ---------------------------------------------------------------------------
// Order reservation amount calculator: package
// Widths, status and register codes, pipeline record types.
// ---------------------------------------------------------------------------
package orac_pkg;

  localparam int AmtBits  = 64;
  localparam int IdBits   = 32;
  localparam int MagBits  = AmtBits - 1;
  localparam int ProdBits = 2 * AmtBits;
  localparam int DivSteps = ProdBits;
  localparam int AddrBits = 6;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StBaseIdZ   = 4'd1,
    StQuoteIdZ  = 4'd2,
    StIdsEq     = 4'd3,
    StBaseScale = 4'd4,
    StNum       = 4'd5,
    StDen       = 4'd6,
    StPrice     = 4'd7,
    StQty       = 4'd8,
    StBaseOvf   = 4'd9,
    StInexact   = 4'd10,
    StQuoteOvf  = 4'd11
  } status_e;

  typedef enum logic [2:0] {
    RegBaseId  = 3'd0,
    RegQuoteId = 3'd1,
    RegBaseSc  = 3'd2,
    RegNum     = 3'd3,
    RegDen     = 3'd4
  } reg_e;

  typedef struct packed {
    logic                side;
    status_e             st;
    logic [MagBits-1:0]  qty;
    logic [AmtBits-1:0]  bp00, bp01, bp10, bp11;
    logic [AmtBits-1:0]  qp00, qp01, qp10, qp11;
  } s1_t;

  typedef struct packed {
    logic                side;
    status_e             st;
    logic [MagBits-1:0]  qty;
    logic [MagBits-1:0]  bamt;
    logic [ProdBits-1:0] dvd;
    logic [AmtBits-1:0]  rem;
    logic [AmtBits-1:0]  quo;
    logic                hinz;
  } dv_t;

  typedef struct packed {
    logic                side;
    status_e             st;
    logic                ovf;
    logic [MagBits-1:0]  bamt;
    logic [AmtBits-1:0]  p00, p01, p10, p11;
  } m_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [MagBits-1:0]  base_amt;
    logic [MagBits-1:0]  quote_amt;
    logic [IdBits-1:0]   reserve_asset;
    logic [MagBits-1:0]  reserve_amount;
  } res_t;

  function automatic logic is_pos(input logic [AmtBits-1:0] v);
    is_pos = (v != '0) && !v[AmtBits-1];
  endfunction

endpackage

@@ rtl/orac_if.sv @@
// ---------------------------------------------------------------------------
// Order reservation amount calculator: channel interfaces
// Order channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface orac_order_if import orac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               side;
  logic [AmtBits-1:0] price;
  logic [AmtBits-1:0] quantity;

  modport source (output valid, side, price, quantity, input ready);
  modport sink (input valid, side, price, quantity, output ready);
endinterface

interface orac_result_if import orac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [MagBits-1:0] base_amt;
  logic [MagBits-1:0] quote_amt;
  logic [IdBits-1:0]  reserve_asset;
  logic [MagBits-1:0] reserve_amount;

  modport source (output valid, status, base_amt, quote_amt, reserve_asset,
                  reserve_amount, input ready);
  modport sink (input valid, status, base_amt, quote_amt, reserve_asset,
                reserve_amount, output ready);
endinterface

@@ rtl/order_reservation_amount_calc.sv @@
// ---------------------------------------------------------------------------
// Order reservation amount calculator
// Checks one order against the configured instrument and returns the asset
// and amount to reserve.
//
//   channel  dir  transaction
//   ord_i    in   side, price, quantity
//   res_o    out  status, base/quote amounts, reserve asset and amount
//   apb      in   instrument registers, 8-byte spaced
//
// One order per cycle when not stalled. Stages: partial products, product sum,
// 128 restoring divide steps (one quotient bit each), rate partial products,
// then the output register. Reset clears valid bits and registers to
// ids 0, scales 1. A stall freezes the pipe only once the skid slot behind
// the output register is full; ord_i.ready is that slot's empty flag.
// ---------------------------------------------------------------------------
`include "order_reservation_amount_calc_defines.svh"

module order_reservation_amount_calc import orac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  orac_order_if.sink          ord_i,
  orac_result_if.source       res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [AmtBits-1:0]  pwdata,
  output logic [AmtBits-1:0]  prdata,
  output logic                pready
);

  logic [IdBits-1:0]  bid_q, qid_q;
  logic [AmtBits-1:0] bsc_q, num_q, den_q;
  reg_e               ridx;

  assign ridx   = reg_e'(paddr[AddrBits-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_q <= '0;
      qid_q <= '0;
      bsc_q <= AmtBits'(1);
      num_q <= AmtBits'(1);
      den_q <= AmtBits'(1);
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegBaseId:  bid_q <= pwdata[IdBits-1:0];
        RegQuoteId: qid_q <= pwdata[IdBits-1:0];
        RegBaseSc:  bsc_q <= pwdata;
        RegNum:     num_q <= pwdata;
        RegDen:     den_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegBaseId:  prdata = AmtBits'(bid_q);
      RegQuoteId: prdata = AmtBits'(qid_q);
      RegBaseSc:  prdata = bsc_q;
      RegNum:     prdata = num_q;
      RegDen:     prdata = den_q;
      default:    prdata = '0;
    endcase
  end

  // pipe control
  logic en, sk_v_q, out_v_q;
  res_t out_q, sk_q;
  assign en          = !sk_v_q;
  assign ord_i.ready = en;

  // entry checks and partial products
  status_e             st0;
  s1_t                 s1_d, s1_q;
  logic                s1_v_q;
  logic [MagBits-1:0]  pm, qm, bm, nm;

  assign pm = ord_i.price[MagBits-1:0];
  assign qm = ord_i.quantity[MagBits-1:0];
  assign bm = bsc_q[MagBits-1:0];
  assign nm = num_q[MagBits-1:0];

  always_comb begin
    if (bid_q == '0)                  st0 = StBaseIdZ;
    else if (qid_q == '0)             st0 = StQuoteIdZ;
    else if (bid_q == qid_q)          st0 = StIdsEq;
    else if (!is_pos(bsc_q))          st0 = StBaseScale;
    else if (!is_pos(num_q))          st0 = StNum;
    else if (!is_pos(den_q))          st0 = StDen;
    else if (!is_pos(ord_i.price))    st0 = StPrice;
    else if (!is_pos(ord_i.quantity)) st0 = StQty;
    else                              st0 = StOk;
    s1_d.side = ord_i.side;
    s1_d.st   = st0;
    s1_d.qty  = qm;
    s1_d.bp00 = qm[31:0] * bm[31:0];
    s1_d.bp01 = qm[31:0] * AmtBits'(bm[MagBits-1:32]);
    s1_d.bp10 = AmtBits'(qm[MagBits-1:32]) * bm[31:0];
    s1_d.bp11 = AmtBits'(qm[MagBits-1:32]) * AmtBits'(bm[MagBits-1:32]);
    s1_d.qp00 = pm[31:0] * nm[31:0];
    s1_d.qp01 = pm[31:0] * AmtBits'(nm[MagBits-1:32]);
    s1_d.qp10 = AmtBits'(pm[MagBits-1:32]) * nm[31:0];
    s1_d.qp11 = AmtBits'(pm[MagBits-1:32]) * AmtBits'(nm[MagBits-1:32]);
  end

  // product sums into divider head
  dv_t                 dv_q [DivSteps+1];
  logic                dv_v_q [DivSteps+1];
  dv_t                 dv0_d;
  logic [ProdBits-1:0] bprod, qprod;

  always_comb begin
    bprod = ProdBits'(s1_q.bp00) + (ProdBits'(s1_q.bp01) << 32)
          + (ProdBits'(s1_q.bp10) << 32) + (ProdBits'(s1_q.bp11) << 64);
    qprod = ProdBits'(s1_q.qp00) + (ProdBits'(s1_q.qp01) << 32)
          + (ProdBits'(s1_q.qp10) << 32) + (ProdBits'(s1_q.qp11) << 64);
    dv0_d.side = s1_q.side;
    dv0_d.st   = s1_q.st;
    if (s1_q.st == StOk && bprod[ProdBits-1:MagBits] != '0) dv0_d.st = StBaseOvf;
    dv0_d.qty  = s1_q.qty;
    dv0_d.bamt = bprod[MagBits-1:0];
    dv0_d.dvd  = qprod;
    dv0_d.rem  = '0;
    dv0_d.quo  = '0;
    dv0_d.hinz = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      s1_v_q    <= ord_i.valid;
      dv_v_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      dv_q[0]  <= dv0_d;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    dv_t             nx;
    logic [AmtBits:0] trial, diff;

    always_comb begin
      nx    = dv_q[k];
      trial = {dv_q[k].rem, dv_q[k].dvd[ProdBits-1]};
      diff  = trial - {1'b0, den_q};
      nx.dvd  = {dv_q[k].dvd[ProdBits-2:0], 1'b0};
      nx.hinz = dv_q[k].hinz | dv_q[k].quo[AmtBits-1];
      if (!diff[AmtBits]) begin
        nx.rem = diff[AmtBits-1:0];
        nx.quo = {dv_q[k].quo[AmtBits-2:0], 1'b1};
      end else begin
        nx.rem = trial[AmtBits-1:0];
        nx.quo = {dv_q[k].quo[AmtBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k+1] <= 1'b0;
      else if (en) dv_v_q[k+1] <= dv_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[k+1] <= nx;
    end
  end

  // rate times quantity partials
  dv_t  dl;
  m_t   m_d, m_q;
  logic m_v_q;

  assign dl = dv_q[DivSteps];

  always_comb begin
    m_d.side = dl.side;
    m_d.st   = dl.st;
    if (dl.st == StOk && dl.rem != '0) m_d.st = StInexact;
    m_d.ovf  = dl.hinz | dl.quo[AmtBits-1];
    m_d.bamt = dl.bamt;
    m_d.p00  = dl.quo[31:0] * dl.qty[31:0];
    m_d.p01  = dl.quo[31:0] * AmtBits'(dl.qty[MagBits-1:32]);
    m_d.p10  = AmtBits'(dl.quo[MagBits-1:32]) * dl.qty[31:0];
    m_d.p11  = AmtBits'(dl.quo[MagBits-1:32]) * AmtBits'(dl.qty[MagBits-1:32]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else if (en) m_v_q <= dv_v_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    if (en) m_q <= m_d;
  end

  // final status and result
  logic [ProdBits-1:0] rprod;
  status_e             stf;
  res_t                f;

  always_comb begin
    rprod = ProdBits'(m_q.p00) + (ProdBits'(m_q.p01) << 32)
          + (ProdBits'(m_q.p10) << 32) + (ProdBits'(m_q.p11) << 64);
    stf = m_q.st;
    if (stf == StOk && (m_q.ovf || rprod[ProdBits-1:MagBits] != '0)) stf = StQuoteOvf;
    f.status        = stf;
    f.base_amt      = (stf == StOk) ? m_q.bamt : '0;
    f.quote_amt     = (stf == StOk) ? rprod[MagBits-1:0] : '0;
    f.reserve_asset = m_q.side ? bid_q : qid_q;
    f.reserve_amount = m_q.side ? f.base_amt : f.quote_amt;
  end

  // output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (res_o.ready) sk_v_q <= 1'b0;
    end else if (m_v_q) begin
      if (!out_v_q || res_o.ready) out_v_q <= 1'b1;
      else sk_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (res_o.ready) out_q <= sk_q;
    end else if (m_v_q) begin
      if (!out_v_q || res_o.ready) out_q <= f;
      else sk_q <= f;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.status         = out_q.status;
  assign res_o.base_amt       = out_q.base_amt;
  assign res_o.quote_amt      = out_q.quote_amt;
  assign res_o.reserve_asset  = out_q.reserve_asset;
  assign res_o.reserve_amount = out_q.reserve_amount;

  `ORAC_ASSERT_NEVER(a_skid_alone, sk_v_q && !out_v_q, "skid full with empty output")
  `ORAC_ASSERT_IMP(a_err_zero, out_v_q && out_q.status != StOk,
    out_q.base_amt == '0 && out_q.quote_amt == '0 && out_q.reserve_amount == '0,
    "nonzero amount on error")
  `ORAC_ASSERT_IMP(a_ok_pos, out_v_q && out_q.status == StOk,
    out_q.base_amt != '0 && out_q.quote_amt != '0, "zero amount on ok")

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// Order reservation amount calculator testbench
// Drives orders through the valid/ready order channel and programs the
// instrument over APB between phases. A directed table covers every status
// code and the field extremes. Random phases follow, with random instrument
// settings and orders. Results are checked against typed table rows or an
// in-bench reservation predictor. Both channel sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import orac_pkg::*;

  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin = 64'h8000_0000_0000_0000;

  typedef struct {
    bit          is_cfg;
    reg_e        rg;
    logic [63:0] val;
    logic        side;
    logic [63:0] price;
    logic [63:0] qty;
    bit          typed;
    status_e     st;
    logic [31:0] asset;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrBits-1:0] paddr;
  logic [63:0] pwdata, prdata;

  orac_order_if  ord ();
  orac_result_if res ();

  order_reservation_amount_calc dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ord_i   (ord.sink),
    .res_o   (res.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] inst_base_id, inst_quote_id;
  logic [63:0] inst_base_sc, inst_num, inst_den;

  res_t reservation_q[$];
  int   mismatches;
  bit   calm;
  row_t rows[$];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit positive(input logic [63:0] v);
    return v != '0 && !v[63];
  endfunction

  function automatic res_t predict_reservation(input logic side, input logic [63:0] price,
                                               input logic [63:0] qty);
    res_t        r;
    logic [127:0] bprod, qprod, rate, rem, qamt;
    status_e     st;
    st = StOk;
    r  = '0;
    if (inst_base_id == 0)                 st = StBaseIdZ;
    else if (inst_quote_id == 0)           st = StQuoteIdZ;
    else if (inst_base_id == inst_quote_id) st = StIdsEq;
    else if (!positive(inst_base_sc))      st = StBaseScale;
    else if (!positive(inst_num))          st = StNum;
    else if (!positive(inst_den))          st = StDen;
    else if (!positive(price))             st = StPrice;
    else if (!positive(qty))               st = StQty;
    else begin
      bprod = {64'd0, qty} * {64'd0, inst_base_sc};
      qprod = {64'd0, price} * {64'd0, inst_num};
      rate  = qprod / {64'd0, inst_den};
      rem   = qprod % {64'd0, inst_den};
      qamt  = {64'd0, rate[63:0]} * {64'd0, qty};
      if (bprod > {64'd0, SMax})                     st = StBaseOvf;
      else if (rem != 0)                              st = StInexact;
      else if (rate[127:64] != 0 || qamt > {64'd0, SMax}) st = StQuoteOvf;
      else begin
        r.base_amt  = bprod[62:0];
        r.quote_amt = qamt[62:0];
      end
    end
    r.status         = st;
    r.reserve_asset  = side ? inst_base_id : inst_quote_id;
    r.reserve_amount = side ? r.base_amt : r.quote_amt;
    return r;
  endfunction

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && res.valid && res.ready) begin
      if (reservation_q.size() == 0) begin
        report("unexpected transaction", res.status, 0);
      end else begin
        w = reservation_q.pop_front();
        if (res.status !== w.status) report("status", res.status, w.status);
        if (res.base_amt !== w.base_amt)
          report("base_amt", res.base_amt, w.base_amt);
        if (res.quote_amt !== w.quote_amt)
          report("quote_amt", res.quote_amt, w.quote_amt);
        if (res.reserve_asset !== w.reserve_asset)
          report("reserve_asset", res.reserve_asset, w.reserve_asset);
        if (res.reserve_amount !== w.reserve_amount)
          report("reserve_amount", res.reserve_amount, w.reserve_amount);
      end
    end
    res.ready <= calm || ($urandom_range(99) >= 25);
  end

  task automatic write_reg(input reg_e rg, input logic [63:0] val);
    ord.valid <= 1'b0;
    wait (reservation_q.size() == 0);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrBits'(8 * int'(rg));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (rg)
      RegBaseId:  inst_base_id  = val[31:0];
      RegQuoteId: inst_quote_id = val[31:0];
      RegBaseSc:  inst_base_sc  = val;
      RegNum:     inst_num      = val;
      RegDen:     inst_den      = val;
      default: ;
    endcase
  endtask

  task automatic send_order(input logic side, input logic [63:0] price, input logic [63:0] qty,
                            input bit typed, input res_t typed_res);
    while (!calm && $urandom_range(99) < 25) begin
      ord.valid <= 1'b0;
      @(posedge clk_i);
    end
    ord.valid    <= 1'b1;
    ord.side     <= side;
    ord.price    <= price;
    ord.quantity <= qty;
    @(posedge clk_i);
    while (!ord.ready) @(posedge clk_i);
    reservation_q.push_back(typed ? typed_res : predict_reservation(side, price, qty));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_amount();
    case ($urandom_range(9))
      0:       return rand64();
      1: begin
        case ($urandom_range(4))
          0: return 64'd0;
          1: return 64'd1;
          2: return SMax;
          3: return SMin;
          default: return '1;
        endcase
      end
      2:       return rand64() >> $urandom_range(63, 1);
      default: return 64'($urandom_range(10000, 1));
    endcase
  endfunction

  task automatic add_cfg(input reg_e rg, input logic [63:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.rg     = rg;
    r.val    = val;
    r.side   = 1'b0;
    r.price  = '0;
    r.qty    = '0;
    r.typed  = 1'b0;
    r.st     = StOk;
    r.asset  = '0;
    rows.push_back(r);
  endtask

  task automatic add_order(input logic side, input logic [63:0] price, input logic [63:0] qty,
                           input bit typed, input status_e st, input logic [31:0] asset);
    row_t r;
    r.is_cfg = 1'b0;
    r.rg    = RegBaseId;
    r.val   = '0;
    r.side  = side;
    r.price = price;
    r.qty   = qty;
    r.typed = typed;
    r.st    = st;
    r.asset = asset;
    rows.push_back(r);
  endtask

  initial begin
    res_t  tr;
    int    sent;
    int    n;
    logic [31:0] a, b;
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    ord.valid = 1'b0;
    ord.side  = 1'b0;
    ord.price = '0;
    ord.quantity = '0;
    res.ready = 1'b0;
    mismatches = 0;
    calm = 1'b0;
    inst_base_id = 0;
    inst_quote_id = 0;
    inst_base_sc = 1;
    inst_num = 1;
    inst_den = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_order(1'b0, 64'd5, 64'd3, 1, StBaseIdZ, 32'd0);
    add_cfg(RegBaseId, 64'd7);
    add_order(1'b1, 64'd5, 64'd3, 1, StQuoteIdZ, 32'd7);
    add_cfg(RegQuoteId, 64'd7);
    add_order(1'b0, 64'd5, 64'd3, 1, StIdsEq, 32'd7);
    add_cfg(RegQuoteId, 64'hFFFF_FFFF);
    add_cfg(RegBaseSc, 64'd0);
    add_order(1'b0, 64'd5, 64'd3, 1, StBaseScale, 32'hFFFF_FFFF);
    add_cfg(RegBaseSc, SMin);
    add_order(1'b1, 64'd5, 64'd3, 1, StBaseScale, 32'd7);
    add_cfg(RegBaseSc, 64'd10);
    add_cfg(RegNum, '1);
    add_order(1'b0, 64'd5, 64'd3, 1, StNum, 32'hFFFF_FFFF);
    add_cfg(RegNum, 64'd3);
    add_cfg(RegDen, 64'd0);
    add_order(1'b0, 64'd5, 64'd3, 1, StDen, 32'hFFFF_FFFF);
    add_cfg(RegDen, 64'd2);
    add_order(1'b0, 64'd0, 64'd3, 1, StPrice, 32'hFFFF_FFFF);
    add_order(1'b1, SMin, 64'd3, 1, StPrice, 32'd7);
    add_order(1'b0, 64'd4, 64'd0, 1, StQty, 32'hFFFF_FFFF);
    add_order(1'b0, 64'd4, SMin, 1, StQty, 32'hFFFF_FFFF);
    add_order(1'b0, 64'd4, 64'd5, 0, StOk, 0);
    add_order(1'b1, 64'd4, 64'd5, 0, StOk, 0);
    add_order(1'b0, 64'd3, 64'd1, 1, StInexact, 32'hFFFF_FFFF);
    add_order(1'b1, 64'd4, SMax, 1, StBaseOvf, 32'd7);
    add_cfg(RegBaseSc, 64'd1);
    add_order(1'b0, SMax - 1, 64'd1, 1, StQuoteOvf, 32'hFFFF_FFFF);
    add_order(1'b0, 64'd2, SMax, 1, StQuoteOvf, 32'hFFFF_FFFF);
    add_order(1'b1, SMax, SMax, 0, StOk, 0);
    add_cfg(RegBaseId, 64'hFFFF_FFFF);
    add_cfg(RegQuoteId, 64'd1);
    add_cfg(RegNum, SMax);
    add_cfg(RegDen, SMax);
    add_order(1'b0, SMax, SMax, 0, StOk, 0);
    add_order(1'b1, 64'd1, 64'd1, 0, StOk, 0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].rg, rows[i].val);
      end else begin
        tr = '0;
        tr.status = rows[i].st;
        tr.reserve_asset = rows[i].asset;
        send_order(rows[i].side, rows[i].price, rows[i].qty, rows[i].typed, tr);
      end
    end

    sent = 0;
    while (sent < 900) begin
      ord.valid <= 1'b0;
      a = $urandom_range(9) == 0 ? $urandom_range(3) : $urandom();
      b = $urandom_range(9) == 0 ? a : $urandom();
      write_reg(RegBaseId, 64'(a));
      write_reg(RegQuoteId, 64'(b));
      write_reg(RegBaseSc, $urandom_range(9) == 0 ? rand64() : 64'($urandom_range(1000, 1)));
      write_reg(RegNum, $urandom_range(9) == 0 ? rand64() : 64'($urandom_range(1000, 1)));
      case ($urandom_range(9))
        0:       write_reg(RegDen, rand64());
        1:       write_reg(RegDen, SMax);
        default: write_reg(RegDen, 64'($urandom_range(5, 1)));
      endcase
      n = $urandom_range(120, 60);
      for (int k = 0; k < n; k++) begin
        calm = (sent >= 300 && sent < 450);
        send_order(1'($urandom_range(1)), rand_amount(), rand_amount(), 0, '0);
        sent++;
      end
    end
    ord.valid <= 1'b0;
    calm = 1'b0;

    wait (reservation_q.size() == 0);
    repeat (140) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/orac_pkg.sv
rtl/orac_if.sv
rtl/order_reservation_amount_calc.sv
test/tb_top.sv
